// ----- hdl/vfme_pkg.sv -----
// Shared types, constants and lookup tables for the voxel face mesh emitter.
// No dependencies; every other file imports this package.
package vfme_pkg;

	localparam int MAX_FACES  = 65536;
	localparam int CNT_W      = $clog2(MAX_FACES + 1);
	localparam int POS_W      = 15;
	localparam int VERT_W     = 17;
	localparam int VIDX_W     = 18;
	localparam int TEX_W      = 9;
	localparam int TYPE_W     = 4;
	localparam int NFACE      = 6;
	localparam int FACE_W     = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// face codes, in emission order
	localparam logic [FACE_W-1:0] FACE_UP     = 3'd0;
	localparam logic [FACE_W-1:0] FACE_DOWN   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_X  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_X  = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Z  = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z  = 3'd5;

	// tile table column selects
	localparam logic [1:0] KIND_TOP    = 2'd0;
	localparam logic [1:0] KIND_BOTTOM = 2'd1;
	localparam logic [1:0] KIND_SIDE   = 2'd2;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [TYPE_W-1:0]       block_type;
		logic [NFACE-1:0]        mask;
		logic [CNT_W-1:0]        slot;
	} job_t;

	function automatic logic [1:0] face_kind(input logic [FACE_W-1:0] face);
		logic [1:0] k;
		case (face)
			FACE_UP:   k = KIND_TOP;
			FACE_DOWN: k = KIND_BOTTOM;
			default:   k = KIND_SIDE;
		endcase
		return k;
	endfunction

	// packed {top, bottom, side}, two bits each
	function automatic logic [1:0] tile_col(input logic [TYPE_W-1:0] t, input logic [1:0] kind);
		logic [5:0] c;
		case (t)
			4'd0:    c = {2'd3, 2'd1, 2'd0};
			4'd1:    c = {2'd1, 2'd1, 2'd1};
			4'd2:    c = {2'd3, 2'd3, 2'd3};
			4'd3:    c = {2'd0, 2'd0, 2'd0};
			4'd4:    c = {2'd0, 2'd0, 2'd0};
			4'd5:    c = {2'd2, 2'd2, 2'd2};
			4'd6:    c = {2'd1, 2'd1, 2'd1};
			4'd7:    c = {2'd1, 2'd1, 2'd1};
			4'd8:    c = {2'd0, 2'd2, 2'd3};
			4'd9:    c = {2'd3, 2'd3, 2'd3};
			4'd10:   c = {2'd2, 2'd2, 2'd2};
			4'd11:   c = {2'd1, 2'd1, 2'd1};
			default: c = {2'd1, 2'd1, 2'd1};
		endcase
		case (kind)
			KIND_TOP:    return c[5:4];
			KIND_BOTTOM: return c[3:2];
			default:     return c[1:0];
		endcase
	endfunction

	function automatic logic [1:0] tile_row(input logic [TYPE_W-1:0] t, input logic [1:0] kind);
		logic [5:0] r;
		case (t)
			4'd0:    r = {2'd0, 2'd0, 2'd1};
			4'd1:    r = {2'd0, 2'd0, 2'd0};
			4'd2:    r = {2'd1, 2'd1, 2'd1};
			4'd3:    r = {2'd2, 2'd2, 2'd2};
			4'd4:    r = {2'd0, 2'd0, 2'd0};
			4'd5:    r = {2'd0, 2'd0, 2'd0};
			4'd6:    r = {2'd2, 2'd2, 2'd2};
			4'd7:    r = {2'd2, 2'd2, 2'd2};
			4'd8:    r = {2'd3, 2'd2, 2'd2};
			4'd9:    r = {2'd3, 2'd3, 2'd3};
			4'd10:   r = {2'd3, 2'd3, 2'd3};
			4'd11:   r = {2'd3, 2'd3, 2'd3};
			default: r = {2'd0, 2'd0, 2'd0};
		endcase
		case (kind)
			KIND_TOP:    return r[5:4];
			KIND_BOTTOM: return r[3:2];
			default:     return r[1:0];
		endcase
	endfunction

	// corner direction per face and corner: {x, y, z}, 1 means +1 half unit
	function automatic logic [2:0] corner_dir(input logic [FACE_W-1:0] face,
			input logic [1:0] corner);
		logic [11:0] d;
		case (face)
			FACE_UP:     d = {3'b011, 3'b111, 3'b110, 3'b010};
			FACE_DOWN:   d = {3'b000, 3'b100, 3'b101, 3'b001};
			FACE_POS_X:  d = {3'b110, 3'b111, 3'b101, 3'b100};
			FACE_NEG_X:  d = {3'b011, 3'b010, 3'b000, 3'b001};
			FACE_POS_Z:  d = {3'b011, 3'b111, 3'b101, 3'b001};
			FACE_NEG_Z:  d = {3'b110, 3'b010, 3'b000, 3'b100};
			default:     d = '0;
		endcase
		case (corner)
			2'd0:    return d[11:9];
			2'd1:    return d[8:6];
			2'd2:    return d[5:3];
			default: return d[2:0];
		endcase
	endfunction

	function automatic logic [VERT_W-1:0] half_coord(input logic [POS_W-1:0] p,
			input logic plus);
		logic [VERT_W-1:0] base;
		base = {p[POS_W-1], p, 1'b0};
		return plus ? (base | VERT_W'(1)) : (base - VERT_W'(1));
	endfunction

	// near edge col*64+2, far edge (col+1)*64-2
	function automatic logic [TEX_W-1:0] tex_coord(input logic [1:0] tile, input logic far);
		logic [TEX_W-1:0] edge0;
		edge0 = {1'b0, tile, 6'd0};
		return far ? (edge0 + TEX_W'(62)) : (edge0 + TEX_W'(2));
	endfunction

endpackage

// ----- hdl/vfme_front.sv -----
// Front end: takes cubes, applies culling, allocates face slots from the face counter.
// Depends on vfme_pkg; feeds jobs into vfme_fifo.
module vfme_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	input  logic                          first_of_batch,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_x,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_y,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_z,
	input  logic [vfme_pkg::TYPE_W-1:0]   block_type,
	input  logic [vfme_pkg::NFACE-1:0]    face_mask,
	output logic                          job_valid,
	output vfme_pkg::job_t                job
);
	import vfme_pkg::*;

	logic             culling_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] room;
	logic [NFACE-1:0] vis;
	logic [NFACE-1:0] keep;
	logic [2:0]       pop_cnt;
	logic [2:0]       take;
	logic [2:0]       taken;

	always_comb begin
		cnt_eff = first_of_batch ? '0 : cnt_q;
		vis     = culling_q ? face_mask : '1;
		room    = (cnt_eff >= CNT_W'(MAX_FACES)) ? '0 : (CNT_W'(MAX_FACES) - cnt_eff);
		pop_cnt = '0;
		for (int f = 0; f < NFACE; f++) begin
			pop_cnt = pop_cnt + 3'(vis[f]);
		end
		take = (CNT_W'(pop_cnt) > room) ? room[2:0] : pop_cnt;
		// keep the first visible faces that still fit
		keep  = '0;
		taken = '0;
		for (int f = 0; f < NFACE; f++) begin
			if (vis[f] && (taken < take)) begin
				keep[f] = 1'b1;
			end
			taken = taken + 3'(vis[f]);
		end
	end

	assign job_valid      = in_valid && (keep != '0);
	assign job.pos_x      = pos_x;
	assign job.pos_y      = pos_y;
	assign job.pos_z      = pos_z;
	assign job.block_type = block_type;
	assign job.mask       = keep;
	assign job.slot       = cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			culling_q <= 1'b1;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid) begin
				culling_q <= cfg_data;
			end
			if (in_valid) begin
				cnt_q <= cnt_eff + CNT_W'(take);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FACES))
		else $error("face counter above capacity");

	a_slot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (job.slot < CNT_W'(MAX_FACES)))
		else $error("job issued with counter full");

endmodule

// ----- hdl/vfme_fifo.sv -----
// Short job queue between the front end and the vertex generator.
// Depends on vfme_pkg for the job type and depth.
module vfme_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  vfme_pkg::job_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output vfme_pkg::job_t rd_data,
	output logic           not_empty
);
	import vfme_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rptr_q];
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue count above depth");

endmodule

// ----- hdl/vfme_back.sv -----
// Vertex generator: walks the kept faces of one job, four corners each, one vertex a cycle
// while pop drains its output register. Depends on vfme_pkg; reads jobs from vfme_fifo.
module vfme_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_avail,
	input  vfme_pkg::job_t                 job,
	output logic                           job_take,
	output logic                           empty,
	input  logic                           pop,
	output logic [vfme_pkg::VIDX_W-1:0]    vertex_index,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_x,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_y,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_z,
	output logic [vfme_pkg::TEX_W-1:0]     tex_u,
	output logic [vfme_pkg::TEX_W-1:0]     tex_v,
	output logic [vfme_pkg::FACE_W-1:0]    face_number,
	output logic                           last
);
	import vfme_pkg::*;

	job_t              job_q;
	logic              busy_q;
	logic [1:0]        corner_q;
	logic              out_valid_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [VERT_W-1:0] vx_q;
	logic [VERT_W-1:0] vy_q;
	logic [VERT_W-1:0] vz_q;
	logic [TEX_W-1:0]  u_q;
	logic [TEX_W-1:0]  v_q;
	logic [FACE_W-1:0] face_q;
	logic              last_q;

	logic [FACE_W-1:0] face_sel;
	logic [NFACE-1:0]  rest_mask;
	logic [1:0]        kind;
	logic [2:0]        dir;
	logic              far_u;
	logic              far_v;
	logic              vtx_last;
	logic              advance;

	always_comb begin
		// lowest pending face goes first
		face_sel = '0;
		for (int f = NFACE - 1; f >= 0; f--) begin
			if (job_q.mask[f]) begin
				face_sel = FACE_W'(f);
			end
		end
		rest_mask = job_q.mask & ~(NFACE'(1) << face_sel);
		kind      = face_kind(face_sel);
		dir       = corner_dir(face_sel, corner_q);
		far_u     = (corner_q == 2'd1) || (corner_q == 2'd2);
		far_v     = corner_q[1];
		vtx_last  = (corner_q == CORNER_LAST) && (rest_mask == '0);
	end

	assign advance  = busy_q && (!out_valid_q || pop);
	assign job_take = job_avail && (!busy_q || (advance && vtx_last));

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end else if (advance && (corner_q == CORNER_LAST)) begin
			job_q.mask <= rest_mask;
			job_q.slot <= job_q.slot + CNT_W'(1);
		end
		if (advance) begin
			vidx_q <= VIDX_W'({job_q.slot, corner_q});
			vx_q   <= half_coord(job_q.pos_x, dir[2]);
			vy_q   <= half_coord(job_q.pos_y, dir[1]);
			vz_q   <= half_coord(job_q.pos_z, dir[0]);
			u_q    <= tex_coord(tile_col(job_q.block_type, kind), far_u);
			v_q    <= tex_coord(tile_row(job_q.block_type, kind), far_v);
			face_q <= face_sel;
			last_q <= vtx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (job_take) begin
				busy_q   <= 1'b1;
				corner_q <= '0;
			end else if (advance) begin
				corner_q <= corner_q + 2'd1;
				if (vtx_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign empty        = !out_valid_q;
	assign vertex_index = vidx_q;
	assign vert_x       = vx_q;
	assign vert_y       = vy_q;
	assign vert_z       = vz_q;
	assign tex_u        = u_q;
	assign tex_v        = v_q;
	assign face_number  = face_q;
	assign last         = last_q;

	a_busy_mask: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (job_q.mask != '0))
		else $error("active job with no faces left");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (vidx_q[1:0] == CORNER_LAST))
		else $error("last flag on a corner other than the final one");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (face_q <= FACE_NEG_Z))
		else $error("face number out of range");

endmodule

// ----- hdl/voxel_face_mesh_emitter.sv -----
// Voxel face mesh emitter: turns cubes with a visible-face mask into four vertices per face,
// one vertex per cycle once a cube is queued and while pop drains the output register.
// A cube is taken each cycle while the four-entry job queue has room; the vertex generator
// then emits four vertices per kept face, so sustained throughput is set by that
// one-vertex-a-cycle loop and by how quickly pop drains the output register. Faces past
// the capacity of MAX_FACES slots are dropped; a cube with no kept face produces no vertex.
// Depends on vfme_pkg, vfme_front, vfme_fifo and vfme_back.
module voxel_face_mesh_emitter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic                           first_of_batch,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_x,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_y,
	input  logic signed [vfme_pkg::POS_W-1:0] pos_z,
	input  logic [vfme_pkg::TYPE_W-1:0]    block_type,
	input  logic [vfme_pkg::NFACE-1:0]     face_mask,
	output logic                           empty,
	input  logic                           pop,
	output logic [vfme_pkg::VIDX_W-1:0]    vertex_index,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_x,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_y,
	output logic signed [vfme_pkg::VERT_W-1:0] vert_z,
	output logic [vfme_pkg::TEX_W-1:0]     tex_u,
	output logic [vfme_pkg::TEX_W-1:0]     tex_v,
	output logic [vfme_pkg::FACE_W-1:0]    face_number,
	output logic                           last
);
	import vfme_pkg::*;

	logic in_beat;
	logic job_valid;
	job_t job_in;
	job_t job_out;
	logic job_avail;
	logic job_take;

	assign cfg_ready = 1'b1;
	assign in_beat   = push && !full;

	vfme_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.in_valid       (in_beat),
		.first_of_batch (first_of_batch),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.block_type     (block_type),
		.face_mask      (face_mask),
		.job_valid      (job_valid),
		.job            (job_in)
	);

	vfme_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_valid),
		.wr_data   (job_in),
		.full      (full),
		.rd_en     (job_take),
		.rd_data   (job_out),
		.not_empty (job_avail)
	);

	vfme_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (job_avail),
		.job          (job_out),
		.job_take     (job_take),
		.empty        (empty),
		.pop          (pop),
		.vertex_index (vertex_index),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_z       (vert_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.face_number  (face_number),
		.last         (last)
	);

endmodule
